// ----- src/bounded_deque_unit_defines.svh -----
// Assertion macros shared by the bounded deque unit modules.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef BOUNDED_DEQUE_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset
`define BDQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BDQ_ASSERT(label, prop, msg)
`define BDQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- src/bdq_pkg.sv -----
// Shared constants, codes and types for the bounded deque unit.
// No dependencies; imported by every module of the block.
package bdq_pkg;

   // Ring storage size; must be a power of two so the indices wrap naturally
   localparam int DEPTH     = 64;
   localparam int PAYLOAD_W = 32;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int CAP_W     = 7;
   localparam int OCC_W     = 7;
   localparam int MODE_W    = 3;
   localparam int STATUS_W  = 2;

   // Operation codes carried in the request tuser
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FINISH     = 3'd4;

   // Result status codes carried in the response tuser
   localparam logic [STATUS_W-1:0] STATUS_DONE           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL           = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_WOULD_BLOCK    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY_FINISHED = 2'd3;

   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic latch;   // capture the accepted item
      logic exec;    // update ring, indices and count
      logic load;    // load the response register
   } bdq_cmd_type;

endpackage

// ----- src/bdq_ctrl.sv -----
// Controller of the bounded deque unit: sequences latch, execute and load.
// Depends on bdq_pkg and bounded_deque_unit_defines.svh.
`include "bounded_deque_unit_defines.svh"
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output bdq_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Response register can take a new item when empty or draining now
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state and commands; take an item only outside reset
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !reset) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response valid until taken
   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;

   `BDQ_ASSERT_NEXT(a_exec_after_latch, cmd.latch, cmd.exec, "execute did not follow latch")
   `BDQ_ASSERT(a_load_when_free, !cmd.load || out_free, "response loaded over a held item")
   `BDQ_ASSERT_NEXT(a_valid_after_load, cmd.load, rsp_valid_ff, "loaded response not shown")

endmodule

// ----- src/bdq_dp.sv -----
// Datapath of the bounded deque unit: ring memory, indices, count, flag, response.
// Depends on bdq_pkg and bounded_deque_unit_defines.svh.
`include "bounded_deque_unit_defines.svh"
module bdq_dp
   import bdq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  bdq_cmd_type          cmd,
   input  logic [MODE_W-1:0]    mode_in,
   input  logic [PAYLOAD_W-1:0] item_in,
   input  logic                 cap_wr_en,
   input  logic [CAP_W-1:0]     cap_wr_data,
   output logic [PAYLOAD_W-1:0] item_out,
   output logic [STATUS_W-1:0]  status_out,
   output logic [OCC_W-1:0]     occupancy_out
);

   logic [PAYLOAD_W-1:0] slot_mem [DEPTH];

   logic [MODE_W-1:0]    mode_ff;
   logic [PAYLOAD_W-1:0] item_ff;
   logic [CAP_W-1:0]     capacity_ff;
   logic [ADDR_W-1:0]    front_ff, front_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 finished_ff, finished_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 pop_ok_ff;
   logic [PAYLOAD_W-1:0] rd_data_ff;
   logic [PAYLOAD_W-1:0] item_out_ff;
   logic [STATUS_W-1:0]  status_out_ff;
   logic [OCC_W-1:0]     occupancy_ff;

   logic [CNT_W-1:0]     cap_eff;
   logic [ADDR_W-1:0]    cnt_lo;
   logic [ADDR_W-1:0]    addr;
   logic                 is_full, is_empty;
   logic                 push_ok, pop_ok;

   // Clamp capacity to the ring size
   assign cap_eff  = (32'(capacity_ff) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity_ff);
   assign is_full  = (count_ff >= cap_eff);
   assign is_empty = (count_ff == '0);
   assign cnt_lo   = count_ff[ADDR_W-1:0];

   // Decode the operation: slot address, next indices, status
   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      finished_in = finished_ff;
      status_in   = STATUS_DONE;
      addr        = front_ff;
      push_ok     = 1'b0;
      pop_ok      = 1'b0;
      unique case (mode_ff)
         MODE_PUSH_FRONT: begin
            addr = front_ff - 1'b1;
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               push_ok  = 1'b1;
               front_in = addr;
               count_in = count_ff + 1'b1;
            end
         end
         MODE_PUSH_REAR: begin
            addr = front_ff + cnt_lo;
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               push_ok  = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         MODE_POP_FRONT: begin
            addr = front_ff;
            if (is_empty) begin
               status_in = finished_ff ? STATUS_EMPTY_FINISHED : STATUS_WOULD_BLOCK;
            end else begin
               pop_ok   = 1'b1;
               front_in = front_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         MODE_POP_REAR: begin
            addr = front_ff + cnt_lo - 1'b1;
            if (is_empty) begin
               status_in = finished_ff ? STATUS_EMPTY_FINISHED : STATUS_WOULD_BLOCK;
            end else begin
               pop_ok   = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         MODE_FINISH: begin
            finished_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Ring memory: one registered read per operation, plus a write on an accepted push
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (push_ok) begin
            slot_mem[addr] <= item_ff;
         end
         rd_data_ff <= slot_mem[addr];
      end
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= mode_in;
         item_ff <= item_in;
      end
   end

   // Control state: indices, count, flag, capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         count_ff    <= '0;
         finished_ff <= 1'b0;
         capacity_ff <= CAP_RESET;
      end else begin
         if (cmd.exec) begin
            front_ff    <= front_in;
            count_ff    <= count_in;
            finished_ff <= finished_in;
         end
         if (cap_wr_en) begin
            capacity_ff <= cap_wr_data;
         end
      end
   end

   // Hold the outcome until the response is loaded
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_out_ff   <= pop_ok_ff ? rd_data_ff : '0;
         status_out_ff <= status_ff;
         occupancy_ff  <= OCC_W'(count_ff);
      end
   end

   assign item_out      = item_out_ff;
   assign status_out    = status_out_ff;
   assign occupancy_out = occupancy_ff;

   `BDQ_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "entry count above ring size")
   `BDQ_ASSERT_NEXT(a_pop_dec, cmd.exec && pop_ok,
      count_ff == $past(count_ff) - 1'b1, "pop did not decrement count")
   `BDQ_ASSERT_NEXT(a_push_inc, cmd.exec && push_ok,
      count_ff == $past(count_ff) + 1'b1, "push did not increment count")

endmodule

// ----- src/bounded_deque_unit.sv -----
// Bounded double-ended queue of 32-bit handles held in a ring memory.
//
// Request channel (req_*): one item per operation; tuser carries the mode
// (push front, push rear, pop front, pop rear, set finished), tdata the handle
// to push. Response channel (rsp_*): exactly one item per request, with the
// popped handle, the status and the occupancy after the operation.
// Configuration: csr_wr_en with csr_wr_data writes the capacity (clamped to
// the ring size); write it only while no request is in flight.
//
// Sequence: after a request is accepted, the ring is updated with a registered
// slot read, then the response is loaded once the response register is free.
// No new request is taken until the current one is through the three-step controller
// sequence (accept, update, load) around the single-port ring memory.
// Reset: synchronous, clears indices, count and finished flag, sets capacity
// to 64, holds req_tready low; ring contents are not cleared.
// Stall: a held response does not block the next request from being taken;
// that request waits in its load step until the response register drains.
// Depends on bdq_pkg, bdq_ctrl, bdq_dp.
module bounded_deque_unit
   import bdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,    // [31:0] item_in
   input  logic [2:0]       req_tuser,    // [2:0] mode
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata,    // [31:0] item_out, [38:32] occupancy, [39] zero
   output logic [1:0]       rsp_tuser,    // [1:0] status
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   bdq_cmd_type          cmd;
   logic [PAYLOAD_W-1:0] item_out;
   logic [STATUS_W-1:0]  status;
   logic [OCC_W-1:0]     occupancy;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   bdq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .mode_in       (req_tuser),
      .item_in       (req_tdata),
      .cap_wr_en     (csr_wr_en),
      .cap_wr_data   (csr_wr_data),
      .item_out      (item_out),
      .status_out    (status),
      .occupancy_out (occupancy)
   );

   // Pack the response fields
   assign rsp_tdata = {1'b0, occupancy, item_out};
   assign rsp_tuser = status;

endmodule

// ----- tb/deque_check_pkg.sv -----
// Scoreboard for the bounded deque unit: a shadow ring that predicts each response.
// Depends on bdq_pkg for widths, operation codes and status codes.
`timescale 1ns / 1ps

package deque_check_pkg;
   import bdq_pkg::*;

   // One predicted response, fields as they travel on the rsp channel
   typedef struct packed {
      logic [PAYLOAD_W-1:0] handle;
      logic [STATUS_W-1:0]  status;
      logic [OCC_W-1:0]     occ;
   } deque_rsp_type;

   class deque_shadow;
      logic [PAYLOAD_W-1:0] ring [DEPTH];
      logic [ADDR_W-1:0]    head;
      logic [CNT_W-1:0]     held;
      bit                   closed;
      logic [CAP_W-1:0]     cap_reg;
      deque_rsp_type        due_rsp [$];
      int unsigned          mismatches;

      function new();
         head       = '0;
         held       = '0;
         closed     = 1'b0;
         cap_reg    = CAP_RESET;
         mismatches = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         cap_reg = value;
      endfunction

      function int unsigned due_count();
         return due_rsp.size();
      endfunction

      // Apply one accepted operation to the shadow ring and queue its response
      function void take_request(logic [MODE_W-1:0] op, logic [PAYLOAD_W-1:0] data);
         int unsigned       limit;
         logic [ADDR_W-1:0] pos;
         deque_rsp_type     r;
         limit    = (cap_reg > DEPTH) ? DEPTH : cap_reg;
         r.handle = '0;
         r.status = STATUS_DONE;
         case (op)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
               if (held >= limit) begin
                  r.status = STATUS_FULL;
               end else if (op == MODE_PUSH_FRONT) begin
                  head       = head - 1'b1;
                  ring[head] = data;
                  held       = held + 1'b1;
               end else begin
                  pos       = head + held[ADDR_W-1:0];
                  ring[pos] = data;
                  held      = held + 1'b1;
               end
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
               if (held == 0) begin
                  r.status = closed ? STATUS_EMPTY_FINISHED : STATUS_WOULD_BLOCK;
               end else if (op == MODE_POP_FRONT) begin
                  r.handle = ring[head];
                  head     = head + 1'b1;
                  held     = held - 1'b1;
               end else begin
                  pos      = head + held[ADDR_W-1:0] - 1'b1;
                  r.handle = ring[pos];
                  held     = held - 1'b1;
               end
            end
            MODE_FINISH: closed = 1'b1;
            default: ;
         endcase
         r.occ = held;
         due_rsp.push_back(r);
      endfunction

      // Compare one accepted response against the oldest prediction
      function void check_response(logic [PAYLOAD_W-1:0] handle, logic [STATUS_W-1:0] status,
                                   logic [OCC_W-1:0] occ, logic pad);
         deque_rsp_type e;
         if (due_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: item %h status %0d occ %0d", handle, status, occ);
            return;
         end
         e = due_rsp.pop_front();
         if (handle !== e.handle || status !== e.status || occ !== e.occ || pad !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp item %h status %0d occ %0d, %s %h status %0d occ %0d pad %b",
                        e.handle, e.status, e.occ, "got item", handle, status, occ, pad);
         end
      endfunction
   endclass

endpackage

// ----- tb/tb_top.sv -----
// Top-level testbench for bounded_deque_unit: directed and random deque operations
// with random stalls on both channels, checked against the deque_shadow scoreboard.
// Depends on bdq_pkg, deque_check_pkg and the bounded_deque_unit RTL.
`timescale 1ns / 1ps

module tb_top;
   import bdq_pkg::*;
   import deque_check_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 8;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata   = '0;
   logic [2:0]        req_tuser   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [39:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              csr_wr_en   = 1'b0;
   logic [CAP_W-1:0]  csr_wr_data = '0;

   deque_shadow       shadow;
   int unsigned       cycles      = 0;
   int unsigned       ready_hold  = 0;

   bounded_deque_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Clock: 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Stall the response side: mostly short gaps, a few long, some long ready stretches
   always @(posedge clock) begin
      int unsigned r;
      r = $urandom_range(0, 99);
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (r < 55) begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 20);
      end else if (r < 65) begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(50, 200);
      end else if (r < 92) begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(10, 40);
      end
   end

   // Check every accepted response item
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         shadow.check_response(rsp_tdata[31:0], rsp_tuser, rsp_tdata[38:32], rsp_tdata[39]);
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_handle();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 32'h0000_0000;
      if (r == 1)
         return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // Choose an operation; fill leans toward pushes, otherwise toward pops
   function automatic logic [2:0] pick_mode(input bit fill);
      int unsigned r;
      logic [2:0]  m;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         m = 3'd5 + 3'($urandom_range(0, 2));
         return m;
      end
      if (r < 5)
         return MODE_FINISH;
      if (fill ? (r < 82) : (r >= 82))
         return $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
      return $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
   endfunction

   // Offer one item, hold it until accepted, then idle for a random gap
   task automatic issue(input logic [2:0] mode, input logic [31:0] data);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      shadow.take_request(mode, data);
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted response has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (shadow.due_count() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow.set_capacity(value);
      @(posedge clock);
   endtask

   initial begin
      logic [CAP_W-1:0] caps  [10];
      int unsigned      sizes [10];
      int unsigned      stretch;
      bit               fill;
      shadow = new();
      caps  = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd3, 7'($urandom_range(2, 63)),
                7'($urandom_range(65, 126)), 7'd64, 7'd2, 7'($urandom_range(1, 64))};
      sizes = '{150, 120, 50, 30, 60, 80, 80, 120, 30, 40};

      // Hold reset, then release it
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty pops while not finished, both ends
      issue(MODE_POP_FRONT, 32'h1111_1111);
      issue(MODE_POP_REAR, 32'h2222_2222);
      // Pushes at both ends, some with extreme handles, then pops at both ends
      issue(MODE_PUSH_FRONT, 32'h0000_0000);
      issue(MODE_PUSH_REAR, 32'hFFFF_FFFF);
      issue(MODE_PUSH_FRONT, 32'hA5A5_A5A5);
      issue(MODE_PUSH_REAR, 32'h5A5A_5A5A);
      issue(MODE_POP_REAR, 32'h0);
      issue(MODE_POP_FRONT, 32'h0);
      // Unused modes change nothing
      issue(3'd5, 32'hFFFF_FFFF);
      issue(3'd6, 32'h8000_0000);
      issue(3'd7, 32'h0000_0001);
      issue(MODE_POP_FRONT, 32'h0);
      issue(MODE_PUSH_REAR, 32'h1234_5678);
      // Capacity lowered below the count: pushes refused while at capacity, pops still work
      write_capacity(7'd1);
      issue(MODE_PUSH_FRONT, 32'hCAFE_0001);
      issue(MODE_POP_REAR, 32'h0);
      issue(MODE_PUSH_REAR, 32'hCAFE_0002);
      issue(MODE_POP_FRONT, 32'h0);
      issue(MODE_PUSH_FRONT, 32'hDEAD_BEEF);
      issue(MODE_PUSH_REAR, 32'hCAFE_0003);
      // Capacity zero refuses every push
      write_capacity(7'd0);
      issue(MODE_PUSH_FRONT, 32'hCAFE_0004);
      issue(MODE_POP_FRONT, 32'h0);
      issue(MODE_PUSH_REAR, 32'hCAFE_0005);
      // Capacity above the ring size; finish, empty pop, push after finish
      write_capacity(7'd127);
      issue(MODE_FINISH, 32'hFFFF_FFFF);
      issue(MODE_POP_REAR, 32'h0);
      issue(MODE_PUSH_FRONT, 32'h8000_0001);
      issue(MODE_POP_FRONT, 32'h0);

      // Random phases; entries carry over so a lower capacity meets a fuller ring
      for (int p = 0; p < 10; p++) begin
         write_capacity(caps[p]);
         stretch = 0;
         fill    = 1'b1;
         for (int i = 0; i < sizes[p]; i++) begin
            if (stretch == 0) begin
               stretch = $urandom_range(10, 80);
               fill    = ~fill;
            end
            stretch--;
            issue(pick_mode(fill), pick_handle());
            if ($urandom_range(0, 59) == 0)
               wait_idle();
         end
      end

      wait_idle();
      repeat (SETTLE) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.due_count() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/bdq_pkg.sv
src/bdq_ctrl.sv
src/bdq_dp.sv
src/bounded_deque_unit.sv
tb/deque_check_pkg.sv
tb/tb_top.sv
